// ----- rtl/npsc_pkg.sv -----
// Package for the neural prescreener: sizes, coefficient slot map and command codes.
// Used by every module of the block; depends on nothing.
package npsc_pkg;

    localparam int WinCols   = 12;
    localparam int WinRows   = 4;
    localparam int PixBits   = 16;
    localparam int Taps      = WinRows * WinCols;
    localparam int L0Bias    = Taps * 4;
    localparam int L1W       = L0Bias + 4;
    localparam int L1Bias    = L1W + 16;
    localparam int L2W       = L1Bias + 4;
    localparam int L2Bias    = L2W + 32;
    localparam int StoreDep  = L2Bias + 4;
    localparam int TapBits   = $clog2(Taps);
    localparam int FillBits  = $clog2(WinCols + 1);
    localparam int Lanes     = 4;

    // per-lane bank of the coefficients after layer 0: slot L0Bias + 4*entry + lane
    localparam int MiscDep    = (StoreDep - L0Bias) / 4;
    localparam int MiscBits   = $clog2(MiscDep);
    localparam int MiscL0Bias = 0;
    localparam int MiscL1W    = (L1W - L0Bias) / 4;
    localparam int MiscL1Bias = (L1Bias - L0Bias) / 4;
    localparam int MiscL2W    = (L2W - L0Bias) / 4;
    localparam int MiscL2Bias = (L2Bias - L0Bias) / 4;

    typedef logic signed [23:0] t_coef;
    typedef logic [PixBits-1:0] t_pix;
    typedef logic [7:0]         t_slot;

    localparam logic CmdLoad  = 1'b0;
    localparam logic CmdPixel = 1'b1;

    typedef enum logic [2:0] {
        t_IDLE = 3'd0, t_L0 = 3'd1, t_L0E = 3'd2, t_L1 = 3'd3,
        t_L1E = 3'd4, t_L2 = 3'd5, t_OUT = 3'd6
    } t_state;

    // per-lane control from the sequencer
    typedef struct packed {
        logic clear;
        logic mac;
    } t_lane_ctl;

endpackage

// ----- rtl/npsc_elliott.sv -----
// Iterative Elliott unit: q = s*65536/(65536+|s|), one quotient bit per cycle.
// Uses npsc_pkg.
module npsc_elliott
    import npsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_s,
    output logic               o_done,
    output logic signed [31:0] o_q
);
    logic [48:0] r_rem;
    logic [32:0] r_den;
    logic [14:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_neg;
    logic        r_busy;
    logic [31:0] mag;
    logic [49:0] trial;

    assign mag   = i_s[31] ? 32'(-i_s) : i_s;
    assign trial = {r_rem, 1'b0} - {17'd0, r_den};

    // restoring division, sixteen quotient bits; remainder always below the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd16;
            r_neg  <= i_s[31];
            r_den  <= 33'd65536 + {1'b0, mag};
            r_rem  <= {17'd0, mag};
            r_quo  <= '0;
        end else if (r_busy) begin
            if (!trial[49]) begin
                r_rem <= trial[48:0];
                r_quo <= {r_quo[13:0], 1'b1};
            end else begin
                r_rem <= {r_rem[47:0], 1'b0};
                r_quo <= {r_quo[13:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) r_busy <= 1'b0;
        end
    end
    assign o_done = r_busy && (r_cnt == 5'd1);
    // quotient below 65536 always; sign restored at the end
    always_comb begin
        logic [15:0] qf;
        qf = !trial[49] ? {r_quo, 1'b1} : {r_quo, 1'b0};
        o_q = r_neg ? -$signed({16'd0, qf}) : $signed({16'd0, qf});
    end
endmodule

// ----- rtl/npsc_lane.sv -----
// One neuron lane: a multiply-accumulate over coefficient and operand pairs.
// Uses npsc_pkg.
module npsc_lane
    import npsc_pkg::*;
(
    input  logic               i_clk,
    input  t_lane_ctl          i_ctl,
    input  t_coef              i_coef,
    input  logic signed [32:0] i_opd,
    output logic signed [63:0] o_acc
);
    logic signed [63:0] r_acc;
    logic signed [56:0] prod;

    assign prod = i_coef * i_opd;

    // accumulate, or load the first product on clear
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear)    r_acc <= 64'(prod);
        else if (i_ctl.mac) r_acc <= r_acc + 64'(prod);
    end
    assign o_acc = r_acc;
endmodule

// ----- rtl/neural_prescreen_three_layer_unit.sv -----
// Top level of the neural prescreener; uses npsc_pkg, npsc_lane, npsc_elliott.
// Coefficients live in per-lane banks; the layer-0 weight banks are read through a register.
//
// A load transaction writes one coefficient word. A pixel transaction shifts a four-row
// column into a twelve-column window; once twelve columns have arrived since a line start it
// yields one use_cubic flag. Four neuron lanes run side by side, one multiply each per
// cycle: layer 0 over the 48 taps and its bias (the window rotates one tap per cycle past
// the lanes), three divisions for the layer-0 Elliott steps, layer 1 over four weights and
// its bias, four more divisions, layer 2 over eight weights and its bias, then the compare.
// The flag is presented after the compare and the next transaction is taken from then on;
// a column that gives a flag is paced by the per-tap multiply loop and the shared bit-serial
// divider. Loads and columns that give no flag are taken in idle, also while an earlier flag
// waits to be taken; the block stalls while it computes a flag and when a new flag is ready
// before the previous one has gone. Coefficients read before they are written are undefined.
module neural_prescreen_three_layer_unit
    import npsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_weight_index,
    input  logic signed [23:0] i_weight_value,
    input  logic [15:0] i_pixel_row0,
    input  logic [15:0] i_pixel_row1,
    input  logic [15:0] i_pixel_row2,
    input  logic [15:0] i_pixel_row3,
    input  logic        i_line_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_use_cubic
);
    // coefficient banks; layer-0 weights per lane, the rest small
    t_coef r_w0 [Lanes][Taps];
    t_coef r_w0_q [Lanes];
    t_coef r_misc [Lanes][MiscDep];
    t_pix  r_win [WinCols][WinRows];
    logic [FillBits-1:0] r_fill, n_fill;

    t_state r_state, n_state;
    logic [TapBits:0] r_step, n_step;
    logic signed [31:0] r_l0 [Lanes];
    logic signed [31:0] r_l1 [Lanes];
    logic [1:0] r_eidx, n_eidx;
    logic r_ostart, n_ostart;
    logic r_ovalid, n_ovalid;
    logic r_flag, n_flag;

    logic acc_ok;
    t_lane_ctl ctl;
    t_coef coef [Lanes];
    logic signed [32:0] opd;
    logic signed [63:0] acc [Lanes];
    logic signed [31:0] div_in, div_q;
    logic div_done;
    logic [TapBits-1:0] w0_addr;

    assign o_ready = (r_state == t_IDLE);
    assign acc_ok  = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_use_cubic = r_flag;

    // layer-0 weight read address runs one step ahead of the lanes
    assign w0_addr = (n_step < (TapBits+1)'(Taps)) ? n_step[TapBits-1:0] : '0;

    // coefficient writes and registered layer-0 weight reads
    always_ff @(posedge i_clk) begin
        if (acc_ok && i_cmd == CmdLoad) begin
            if (i_weight_index < 8'(L0Bias))
                r_w0[i_weight_index[1:0]][TapBits'(i_weight_index[7:2])] <= i_weight_value;
            else if (i_weight_index < 8'(StoreDep))
                r_misc[i_weight_index[1:0]]
                      [MiscBits'(i_weight_index[7:2] - 6'(L0Bias / 4))] <= i_weight_value;
        end
        for (int n = 0; n < Lanes; n++) r_w0_q[n] <= r_w0[n][w0_addr];
    end

    // window shift and fill count
    always_comb begin
        n_fill = i_line_start ? '0 : r_fill;
        if (n_fill < FillBits'(WinCols)) n_fill = n_fill + 1'b1;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int c = 0; c < WinCols; c++)
                for (int r = 0; r < WinRows; r++) r_win[c][r] <= '0;
        end else if (acc_ok && i_cmd == CmdPixel) begin
            r_fill <= n_fill;
            for (int c = 0; c + 1 < WinCols; c++) r_win[c] <= r_win[c+1];
            r_win[WinCols-1][0] <= i_pixel_row0;
            r_win[WinCols-1][1] <= i_pixel_row1;
            r_win[WinCols-1][2] <= i_pixel_row2;
            r_win[WinCols-1][3] <= i_pixel_row3;
        end else if (r_state == t_L0 && r_step < (TapBits+1)'(Taps)) begin
            // row-major rotation by one tap; back in place after a full pass
            for (int c = 0; c + 1 < WinCols; c++) r_win[c] <= r_win[c+1];
            for (int r = 0; r + 1 < WinRows; r++) r_win[WinCols-1][r] <= r_win[0][r+1];
            r_win[WinCols-1][WinRows-1] <= r_win[0][0];
        end
    end

    // operand and coefficient selection per step
    always_comb begin
        logic [MiscBits-1:0] midx;
        midx = '0;
        opd = '0;
        for (int n = 0; n < Lanes; n++) coef[n] = '0;
        case (r_state)
            t_L0: begin
                if (r_step < (TapBits+1)'(Taps)) begin
                    opd = {17'd0, r_win[0][0]};
                    for (int n = 0; n < Lanes; n++) coef[n] = r_w0_q[n];
                end else begin
                    opd  = 33'sd1;
                    midx = MiscBits'(MiscL0Bias);
                    for (int n = 0; n < Lanes; n++) coef[n] = r_misc[n][midx];
                end
            end
            t_L1: begin
                if (r_step < 4) begin
                    opd  = 33'(r_l0[r_step[1:0]]);
                    midx = MiscBits'(MiscL1W) + MiscBits'(r_step[1:0]);
                end else begin
                    opd  = 33'sd65536;
                    midx = MiscBits'(MiscL1Bias);
                end
                for (int n = 0; n < Lanes; n++) coef[n] = r_misc[n][midx];
            end
            t_L2: begin
                if (r_step < 4) begin
                    opd  = 33'(r_l0[r_step[1:0]]);
                    midx = MiscBits'(MiscL2W) + MiscBits'(r_step[2:0]);
                end else if (r_step < 8) begin
                    opd  = 33'(r_l1[r_step[1:0]]);
                    midx = MiscBits'(MiscL2W) + MiscBits'(r_step[2:0]);
                end else begin
                    opd  = 33'sd65536;
                    midx = MiscBits'(MiscL2Bias);
                end
                for (int n = 0; n < Lanes; n++) coef[n] = r_misc[n][midx];
            end
            default: opd = '0;
        endcase
    end

    for (genvar g = 0; g < Lanes; g++) begin : g_lane
        npsc_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_coef (coef[g]),
            .i_opd  (opd),
            .o_acc  (acc[g])
        );
    end

    // saturation helper for lane results
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)       return 32'sh7fffffff;
        else if (x < -64'sd2147483648) return 32'sh80000000;
        else                           return x[31:0];
    endfunction

    always_comb begin
        div_in = (r_state == t_L0E) ? sat32(acc[r_eidx]) : sat32(acc[r_eidx] >>> 16);
    end

    npsc_elliott u_ell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ostart),
        .i_s     (div_in),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // sequencer
    always_comb begin
        logic signed [63:0] lo, hi;
        n_state  = r_state;
        n_step   = r_step;
        n_eidx   = r_eidx;
        n_ostart = 1'b0;
        n_ovalid = r_ovalid && !i_ready;
        n_flag   = r_flag;
        ctl      = '0;
        lo = (acc[0] > acc[1]) ? acc[0] : acc[1];
        hi = (acc[2] > acc[3]) ? acc[2] : acc[3];
        case (r_state)
            t_IDLE: begin
                if (acc_ok && i_cmd == CmdPixel && n_fill == FillBits'(WinCols)) begin
                    n_state = t_L0;
                    n_step  = '0;
                end
            end
            t_L0: begin
                ctl.clear = (r_step == 0);
                ctl.mac   = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == (TapBits+1)'(Taps)) begin
                    n_state = t_L0E; n_eidx = 2'd1; n_ostart = 1'b1;
                end
            end
            t_L0E, t_L1E: begin
                if (div_done) begin
                    if (r_eidx == 2'd3) begin
                        n_state = (r_state == t_L0E) ? t_L1 : t_L2;
                        n_step  = '0;
                    end else begin
                        n_eidx = r_eidx + 2'd1; n_ostart = 1'b1;
                    end
                end
            end
            t_L1: begin
                ctl.clear = (r_step == 0);
                ctl.mac   = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == 4) begin
                    n_state = t_L1E; n_eidx = 2'd0; n_ostart = 1'b1;
                end
            end
            t_L2: begin
                ctl.clear = (r_step == 0);
                ctl.mac   = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == 8) n_state = t_OUT;
            end
            t_OUT: begin
                // wait here while the previous flag is still held by the receiver
                if (!r_ovalid || i_ready) begin
                    n_flag   = (hi <= lo);
                    n_ovalid = 1'b1;
                    n_state  = t_IDLE;
                end
            end
            default: n_state = t_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= t_IDLE;
            r_ovalid <= 1'b0;
            r_ostart <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_ostart <= n_ostart;
        end
        r_step <= n_step;
        r_eidx <= n_eidx;
        r_flag <= n_flag;
    end

    // layer value registers; neuron 0 of layer 0 stays linear
    always_ff @(posedge i_clk) begin
        if (r_state == t_L0 && n_state == t_L0E) begin
            // capture happens next cycle once the sum is final
        end
        if (r_state == t_L0E && r_ostart && r_eidx == 2'd1)
            r_l0[0] <= sat32(acc[0]);
        if (div_done && r_state == t_L0E) r_l0[r_eidx] <= div_q;
        if (div_done && r_state == t_L1E) r_l1[r_eidx] <= div_q;
    end

    // the sequencer only leaves idle for a pixel transaction with a full window
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == t_IDLE && n_state == t_L0) |-> (i_cmd == CmdPixel))
        else $error("compute started without pixel");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != t_IDLE) |-> !o_ready)
        else $error("ready while busy");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == t_OUT) |=> o_valid)
        else $error("result not presented");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_use_cubic)))
        else $error("waiting result dropped or changed");
endmodule
